// ----- hw/rtl/tlef_pkg.sv -----
// ----------------------------------------------------------------------------
// tlef_pkg
// Shared types and constants for the text line number and escape filter.
// ----------------------------------------------------------------------------
package tlef_pkg;

  localparam int NUMBER_DIGITS_DEF = 10;
  localparam int MIN_COLUMNS       = 6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 2;
  localparam int CNT_W      = 5;
  localparam int PAD_W      = 3;
  localparam int BLEN_W     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_NUMBER_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_NONPRINTING = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAB_CARET        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_MARK         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SQUEEZE_BLANK    = 3'd4;

  localparam logic [1:0] NUM_NONE     = 2'd0;
  localparam logic [1:0] NUM_ALL      = 2'd1;
  localparam logic [1:0] NUM_NONBLANK = 2'd2;
  localparam logic [1:0] NUM_SPARE    = 2'd3;

  localparam logic [1:0] LP_TEXT   = 2'd0;
  localparam logic [1:0] LP_START  = 2'd1;
  localparam logic [1:0] LP_BLANK1 = 2'd2;
  localparam logic [1:0] LP_BLANKN = 2'd3;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [3:0] DIGIT_HI  = 4'h3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_PAD,
    ST_DIGIT,
    ST_TAB,
    ST_DOLLAR,
    ST_BODY
  } state_t;

  typedef enum logic [2:0] {
    SRC_SPACE,
    SRC_DIGIT,
    SRC_TAB,
    SRC_DOLLAR,
    SRC_BODY
  } src_t;

  typedef struct packed {
    logic             load;
    logic             incr;
    logic             emit;
    logic             last;
    src_t             sel;
    logic [CNT_W-1:0] idx;
  } ctl_cmd_t;

  typedef struct packed {
    logic              do_num;
    logic              do_dollar;
    logic [BLEN_W-1:0] body_len;
    logic [CNT_W-1:0]  num_len;
    logic [PAD_W-1:0]  pad_len;
    logic              out_free;
  } dp_status_t;

endpackage

// ----- hw/rtl/tlef_ctrl.sv -----
// ----------------------------------------------------------------------------
// tlef_ctrl
// Sequencer: accepts a word, then steps through pad, digits, tab, dollar
// and body bytes, one output word per cycle when the output register frees.
// ----------------------------------------------------------------------------
module tlef_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tlef_pkg::dp_status_t sts,
  output tlef_pkg::ctl_cmd_t   cmd
);
  import tlef_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    cmd.load  = 1'b0;
    cmd.incr  = 1'b0;
    cmd.emit  = 1'b0;
    cmd.last  = 1'b0;
    cmd.sel   = SRC_SPACE;
    cmd.idx   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cnt_nxt = '0;
        if (sts.do_num) begin
          cmd.incr  = 1'b1;
          state_nxt = ST_PAD;
        end else if (sts.do_dollar) begin
          state_nxt = ST_DOLLAR;
        end else if (sts.body_len != '0) begin
          state_nxt = ST_BODY;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PAD: begin
        if (cnt_r >= {{(CNT_W-PAD_W){1'b0}}, sts.pad_len}) begin
          cnt_nxt   = sts.num_len - CNT_W'(1);
          state_nxt = ST_DIGIT;
        end else if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = SRC_SPACE;
          cnt_nxt  = cnt_r + CNT_W'(1);
        end
      end
      ST_DIGIT: begin
        cmd.sel = SRC_DIGIT;
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (cnt_r == '0) begin
            state_nxt = ST_TAB;
          end else begin
            cnt_nxt = cnt_r - CNT_W'(1);
          end
        end
      end
      ST_TAB: begin
        cmd.sel  = SRC_TAB;
        cmd.last = !sts.do_dollar && (sts.body_len == '0);
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cnt_nxt  = '0;
          if (sts.do_dollar) begin
            state_nxt = ST_DOLLAR;
          end else if (sts.body_len != '0) begin
            state_nxt = ST_BODY;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DOLLAR: begin
        cmd.sel  = SRC_DOLLAR;
        cmd.last = (sts.body_len == '0);
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = (sts.body_len == '0) ? ST_IDLE : ST_BODY;
        end
      end
      ST_BODY: begin
        cmd.sel  = SRC_BODY;
        cmd.last = (cnt_r == ({2'b0, sts.body_len} - CNT_W'(1)));
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (cmd.last) begin
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/tlef_dp.sv -----
// ----------------------------------------------------------------------------
// tlef_dp
// Datapath: option registers, line position, BCD line counter, rendered
// body bytes and the output register.
// ----------------------------------------------------------------------------
module tlef_dp #(
  parameter int NUMBER_DIGITS = tlef_pkg::NUMBER_DIGITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tlef_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlef_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [7:0]                     in_byte,
  input  logic                           in_file_start,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [7:0]                     out_byte,
  output logic                           out_last,
  input  tlef_pkg::ctl_cmd_t              cmd,
  output tlef_pkg::dp_status_t            sts
);
  import tlef_pkg::*;

  localparam int DIG_W = $clog2(NUMBER_DIGITS);

  logic [1:0] number_mode_r;
  logic       show_np_r, tab_caret_r, end_mark_r, squeeze_r;
  logic [1:0] line_pos_r, line_pos_nxt;
  logic [3:0] bcd_r [NUMBER_DIGITS];
  logic [3:0] bcd_nxt [NUMBER_DIGITS];
  logic [7:0] body_r [4];
  logic [7:0] body_nxt [4];
  logic [BLEN_W-1:0] body_len_r, body_len_nxt;
  logic       do_num_r, do_num_nxt, do_dollar_r, do_dollar_nxt;
  logic       out_valid_r;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r;
  logic [1:0] lp0;
  logic       is_nl, drop;
  logic [6:0] lo;
  logic [NUMBER_DIGITS:0] carry;
  logic       all_nines;
  logic [CNT_W-1:0] num_len;

  // option registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_mode_r <= NUM_NONE;
      show_np_r     <= 1'b0;
      tab_caret_r   <= 1'b0;
      end_mark_r    <= 1'b0;
      squeeze_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUMBER_MODE:      number_mode_r <= cfg_wdata;
        REG_SHOW_NONPRINTING: show_np_r     <= cfg_wdata[0];
        REG_TAB_CARET:        tab_caret_r   <= cfg_wdata[0];
        REG_END_MARK:         end_mark_r    <= cfg_wdata[0];
        REG_SQUEEZE_BLANK:    squeeze_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // decode of the accepted word
  always_comb begin
    lp0           = in_file_start ? LP_START : line_pos_r;
    is_nl         = (in_byte == CH_NL);
    drop          = 1'b0;
    lo            = in_byte[6:0];
    line_pos_nxt  = LP_TEXT;
    do_num_nxt    = 1'b0;
    do_dollar_nxt = 1'b0;
    body_len_nxt  = BLEN_W'(1);
    for (int i = 0; i < 4; i++) begin
      body_nxt[i] = in_byte;
    end
    if (is_nl) begin
      if (lp0 >= LP_BLANK1) begin
        line_pos_nxt = LP_BLANKN;
        drop         = squeeze_r;
      end else if (lp0 == LP_START) begin
        line_pos_nxt = LP_BLANK1;
      end else begin
        line_pos_nxt = LP_START;
      end
      do_num_nxt    = !drop && (line_pos_nxt >= LP_BLANK1) && (number_mode_r == NUM_ALL);
      do_dollar_nxt = !drop && end_mark_r;
      body_len_nxt  = drop ? '0 : BLEN_W'(1);
    end else begin
      do_num_nxt = (lp0 != LP_TEXT) && (number_mode_r != NUM_NONE);
      if (show_np_r) begin
        if (in_byte < 8'd32) begin
          if (!(in_byte == CH_TAB && !tab_caret_r)) begin
            body_nxt[0]  = CH_CARET;
            body_nxt[1]  = in_byte + 8'd64;
            body_len_nxt = BLEN_W'(2);
          end
        end else if (in_byte == CH_DEL) begin
          body_nxt[0]  = CH_CARET;
          body_nxt[1]  = CH_QMARK;
          body_len_nxt = BLEN_W'(2);
        end else if (in_byte[7]) begin
          body_nxt[0] = CH_M;
          body_nxt[1] = CH_MINUS;
          if (lo < 7'd32) begin
            body_nxt[2]  = CH_CARET;
            body_nxt[3]  = {1'b0, lo} + 8'd64;
            body_len_nxt = BLEN_W'(4);
          end else if (lo < 7'd127) begin
            body_nxt[2]  = {1'b0, lo};
            body_len_nxt = BLEN_W'(3);
          end else begin
            body_nxt[2]  = CH_CARET;
            body_nxt[3]  = CH_QMARK;
            body_len_nxt = BLEN_W'(4);
          end
        end
      end else if (in_byte == CH_TAB && tab_caret_r) begin
        body_nxt[0]  = CH_CARET;
        body_nxt[1]  = in_byte + 8'd64;
        body_len_nxt = BLEN_W'(2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_pos_r  <= LP_START;
      do_num_r    <= 1'b0;
      do_dollar_r <= 1'b0;
      body_len_r  <= '0;
    end else if (cmd.load) begin
      line_pos_r  <= line_pos_nxt;
      do_num_r    <= do_num_nxt;
      do_dollar_r <= do_dollar_nxt;
      body_len_r  <= body_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 4; i++) begin
        body_r[i] <= body_nxt[i];
      end
    end
  end

  // saturating BCD increment
  always_comb begin
    carry[0]  = 1'b1;
    all_nines = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      carry[i+1] = carry[i] && (bcd_r[i] >= 4'd9);
      if (bcd_r[i] != 4'd9) begin
        all_nines = 1'b0;
      end
    end
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (all_nines || !carry[i]) begin
        bcd_nxt[i] = bcd_r[i];
      end else if (bcd_r[i] >= 4'd9) begin
        bcd_nxt[i] = 4'd0;
      end else begin
        bcd_nxt[i] = bcd_r[i] + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
        bcd_r[i] <= 4'd0;
      end
    end else if (cmd.incr) begin
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
        bcd_r[i] <= bcd_nxt[i];
      end
    end
  end

  always_comb begin
    num_len = CNT_W'(1);
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (bcd_r[i] != 4'd0) begin
        num_len = CNT_W'(i + 1);
      end
    end
  end

  // output register
  always_comb begin
    case (cmd.sel)
      SRC_SPACE:  out_byte_nxt = CH_SPACE;
      SRC_DIGIT:  out_byte_nxt = {DIGIT_HI, bcd_r[cmd.idx[DIG_W-1:0]]};
      SRC_TAB:    out_byte_nxt = CH_TAB;
      SRC_DOLLAR: out_byte_nxt = CH_DOLLAR;
      SRC_BODY:   out_byte_nxt = body_r[cmd.idx[1:0]];
      default:    out_byte_nxt = CH_SPACE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte_r <= out_byte_nxt;
      out_last_r <= cmd.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  always_comb begin
    sts.do_num    = do_num_r;
    sts.do_dollar = do_dollar_r;
    sts.body_len  = body_len_r;
    sts.num_len   = num_len;
    sts.pad_len   = (num_len < CNT_W'(MIN_COLUMNS)) ?
                    PAD_W'(CNT_W'(MIN_COLUMNS) - num_len) : '0;
    sts.out_free  = !out_valid_r || out_ready;
  end

endmodule

// ----- hw/rtl/text_line_number_and_escape_filter.sv -----
// ----------------------------------------------------------------------------
// text_line_number_and_escape_filter
// Renders a raw text byte stream with optional line numbers and escapes.
// ----------------------------------------------------------------------------
// One input word is taken at a time. Its setup passes through accept and
// decode, and through a turn from padding to digits when a line number is
// due, then one output word per cycle while the output register is free:
// up to 15 for a numbered line start, otherwise one to four.
// The output register takes the next word whenever it is empty or being
// read, so the output channel sets the pace. A dropped repeated blank line
// passes through accept and decode and gives no output. The BCD line
// counter survives in_file_start and saturates at all nines.
module text_line_number_and_escape_filter #(
  parameter int NUMBER_DIGITS = tlef_pkg::NUMBER_DIGITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tlef_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlef_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_byte,
  input  logic                           in_file_start,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_byte,
  output logic                           out_last
);
  import tlef_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t sts;

  tlef_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tlef_dp #(
    .NUMBER_DIGITS (NUMBER_DIGITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_byte       (in_byte),
    .in_file_start (in_file_start),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_byte      (out_byte),
    .out_last      (out_last),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule
